// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL of the sorted key/value leaf table.
// Needs a clk and an active-low rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks prop at every rising clock edge outside of reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that prop holds in the cycle after trig, outside of reset.
`define ASSERT_NEXT(label, trig, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
        else $error(msg);

`endif

// ===== src/skvl_pkg.sv =====
// Package of the sorted key/value leaf table: field widths, command codes
// and the structs passed between the top level and the cells. No dependencies.
package skvl_pkg;

    localparam int KEY_W   = 32;
    localparam int VAL_W   = 32;
    localparam int TOTAL_W = 5;
    localparam int IN_W    = KEY_W + VAL_W;
    localparam int OUT_W   = 8;

    // Command carried in tuser.
    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_SEARCH = 1'b1
    } cmd_t;

    // One stored entry, handed from a cell to its right neighbor.
    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic signed [VAL_W-1:0] value;
    } entry_t;

    // Broadcast to every cell for the word being accepted.
    typedef struct packed {
        logic                    ins_en;
        logic signed [KEY_W-1:0] key;
        logic signed [VAL_W-1:0] value;
    } cell_bcast_t;

endpackage

// ===== src/skvl_cell.sv =====
// One cell of the sorted chain: holds one key/value entry, compares it with
// the broadcast key and shifts right on insert. Depends on skvl_pkg.
module skvl_cell
    import skvl_pkg::*;
(
    input  logic        clk,
    input  cell_bcast_t bcast,
    input  logic        occupied,
    input  logic        at_end,
    input  logic        greater_prev,
    input  entry_t      entry_prev,
    output logic        greater,
    output logic        match,
    output entry_t      entry
);

    entry_t entry_reg;

    // Compare the stored key with the broadcast key.
    always_comb
    begin
        greater = occupied && (entry_reg.key > bcast.key);
        match   = occupied && (entry_reg.key == bcast.key);
        entry   = entry_reg;
    end

    // On insert, cells past the insert point take their left neighbor's entry;
    // the insert point itself takes the new entry.
    always_ff @(posedge clk)
    begin
        if (bcast.ins_en)
        begin
            if (greater_prev)
            begin
                entry_reg <= entry_prev;
            end
            else if (greater || at_end)
            begin
                entry_reg.key   <= bcast.key;
                entry_reg.value <= bcast.value;
            end
        end
    end

endmodule

// ===== src/sorted_key_value_leaf_table_top.sv =====
// Top level of the sorted key/value leaf table: a chain of skvl_cell entries,
// the entry count, and a registered result stage. Depends on skvl_pkg.
//
// Usage:
// Input words arrive on s_tvalid/s_tready with the command in s_tuser
// (insert or search) and key and value in s_tdata. Each word yields one
// result word on m_tvalid/m_tready carrying found, rejected, is_full and
// the entry count as it stands after the word.
// An insert is placed before the first stored key that is strictly greater,
// so equal keys keep arrival order. An insert into a full table is dropped
// and flagged as rejected. All cells compare and shift in the accept cycle.
// The match bits are registered at the accepting edge and reduced into the
// output register once that register is empty or its word is being taken,
// so a receiver stall can hold the result back in the pending stage.
// A new word is held off until the pending word has moved on, as the match
// register sits between the cell compares and the output register.
// Reset clears the entry count and both valid flags; stored entries are not
// cleared and are never read until written.
// When the receiver stalls, one result waits in the output register and one
// word may still complete its compare; further input is held off.
module sorted_key_value_leaf_table_top
    import skvl_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // key [31:0], value [63:32]
    input  logic             s_tuser,   // command [0]
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata    // found [0], rejected [1], is_full [2],
                                        // entry_total [7:3]
);

`include "assert_macros.svh"

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [CAPACITY-1:0] match_reg;
    logic                pend_reg;
    logic                rej_reg;
    logic                out_valid_reg;
    logic [OUT_W-1:0]    out_data_reg;

    logic                in_fire;
    logic                out_load;
    logic                is_insert;
    logic                table_full;
    logic                ins_ok;
    cell_bcast_t         bcast;
    logic [CAPACITY-1:0] occupied;
    logic [CAPACITY-1:0] at_end;
    logic [CAPACITY-1:0] greater;
    logic [CAPACITY-1:0] match;
    entry_t              entries [CAPACITY];
    logic                found;
    logic [TOTAL_W-1:0]  total;

    // Handshake and command decode.
    always_comb
    begin
        s_tready   = !pend_reg;
        in_fire    = s_tvalid && s_tready;
        is_insert  = (cmd_t'(s_tuser) == CMD_INSERT);
        table_full = (count_reg == CNT_W'(CAPACITY));
        ins_ok     = in_fire && is_insert && !table_full;
        count_next = ins_ok ? count_reg + 1'b1 : count_reg;
        out_load   = pend_reg && (!out_valid_reg || m_tready);

        bcast.ins_en = ins_ok;
        bcast.key    = s_tdata[KEY_W-1:0];
        bcast.value  = s_tdata[IN_W-1:KEY_W];
    end

    // The chain of cells; cell 0 has no left neighbor.
    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic   greater_left;
            entry_t entry_left;

            assign occupied[gi] = (CNT_W'(gi) < count_reg);
            assign at_end[gi]   = (CNT_W'(gi) == count_reg);

            if (gi == 0)
            begin : g_first
                assign greater_left = 1'b0;
                assign entry_left   = entries[0];
            end
            else
            begin : g_rest
                assign greater_left = greater[gi-1];
                assign entry_left   = entries[gi-1];
            end

            skvl_cell u_cell (
                .clk          (clk),
                .bcast        (bcast),
                .occupied     (occupied[gi]),
                .at_end       (at_end[gi]),
                .greater_prev (greater_left),
                .entry_prev   (entry_left),
                .greater      (greater[gi]),
                .match        (match[gi]),
                .entry        (entries[gi])
            );
        end
    endgenerate

    // Entry count and the pending stage holding the match bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (in_fire)
            begin
                pend_reg <= 1'b1;
            end
            else if (out_load)
            begin
                pend_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            match_reg <= is_insert ? '0 : match;
            rej_reg   <= is_insert && table_full;
        end
    end

    // Reduce the match bits and build the result word.
    always_comb
    begin
        found = |match_reg;
        total = TOTAL_W'(count_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= {total, table_full, rej_reg, found};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Checks on the count and the result stage.
    `ASSERT_CLK(a_count_bound, count_reg <= CNT_W'(CAPACITY),
        "entry count exceeds capacity")
    `ASSERT_NEXT(a_insert_grows, ins_ok, count_reg == $past(count_reg) + 1'b1,
        "accepted insert did not grow the count by one")
    `ASSERT_NEXT(a_search_keeps, in_fire && !is_insert, $stable(count_reg),
        "search changed the entry count")
    `ASSERT_CLK(a_reject_full, !(m_tvalid && m_tdata[1]) || (m_tdata[2] && !m_tdata[0]),
        "rejected result without full flag or with found set")

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the sorted key/value leaf table: directed and random
// insert and search words, checked against a predictor of the table contents.
// Depends on skvl_pkg and sorted_key_value_leaf_table_top.
module testbench;
    import skvl_pkg::*;

    localparam int CAPACITY     = 16;
    localparam int RANDOM_WORDS = 1680;
    localparam int LONG_STALL   = 48;
    localparam int DRAIN_CYCLES = 8;

    // One result word, laid out as on m_tdata with found in bit 0.
    typedef struct packed {
        logic [TOTAL_W-1:0] entry_total;
        logic               is_full;
        logic               rejected;
        logic               found;
    } leaf_result_t;

    // Predicts the table contents and checks each result word in order.
    class leaf_table_model #(int DEPTH = 16);
        logic [KEY_W-1:0] keys[DEPTH];
        logic [VAL_W-1:0] values[DEPTH];
        int               count = 0;
        leaf_result_t     expected_results[$];
        int               mismatches = 0;

        // Applies one accepted input word and queues the result it should give.
        function void apply_word(cmd_t cmd, logic [KEY_W-1:0] key,
                                 logic [VAL_W-1:0] value);
            leaf_result_t res;
            int           pos;
            res = '0;
            if (cmd == CMD_INSERT) begin
                if (count >= DEPTH) begin
                    res.rejected = 1'b1;
                end
                else begin
                    // Place before the first stored key that is strictly greater.
                    pos = count;
                    for (int i = 0; i < count; i++) begin
                        if ($signed(keys[i]) > $signed(key)) begin
                            pos = i;
                            break;
                        end
                    end
                    for (int i = count; i > pos; i--) begin
                        keys[i]   = keys[i-1];
                        values[i] = values[i-1];
                    end
                    keys[pos]   = key;
                    values[pos] = value;
                    count++;
                end
            end
            else begin
                for (int i = 0; i < count; i++) begin
                    if (keys[i] == key) begin
                        res.found = 1'b1;
                        break;
                    end
                end
            end
            res.is_full     = (count >= DEPTH);
            res.entry_total = count[TOTAL_W-1:0];
            expected_results.insert(expected_results.size(), res);
        endfunction

        // Compares one result word with the oldest expectation.
        function void check_result(logic [OUT_W-1:0] word);
            leaf_result_t got;
            leaf_result_t exp_res;
            got = leaf_result_t'(word[$bits(leaf_result_t)-1:0]);
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: unexpected result word %h", word);
                return;
            end
            exp_res = expected_results.pop_front();
            if (got.found !== exp_res.found || got.rejected !== exp_res.rejected ||
                got.is_full !== exp_res.is_full ||
                got.entry_total !== exp_res.entry_total) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp f=%0d r=%0d full=%0d n=%0d, got f=%0d r=%0d full=%0d n=%0d",
                             exp_res.found, exp_res.rejected, exp_res.is_full,
                             exp_res.entry_total, got.found, got.rejected,
                             got.is_full, got.entry_total);
            end
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata = '0;
    logic             s_tuser = 1'b0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;

    leaf_table_model #(CAPACITY) table_model;

    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    bit stall_request = 1'b0;

    sorted_key_value_leaf_table_top #(.CAPACITY(CAPACITY)) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #6 clk = ~clk;

    // Hard limit on the run time.
    initial
    begin
        #6000000;
        $display("TB_ERROR");
        $finish;
    end

    // Result side: random stall bursts, plus one long hold-off when requested.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (stall_request) begin
                m_tready = 1'b0;
                repeat (LONG_STALL - 1) @(negedge clk);
                stall_request = 1'b0;
            end
            else if (rx_idle_on && $urandom_range(0, 9) == 0) begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 12) - 1) @(negedge clk);
            end
            else begin
                m_tready = 1'b1;
            end
        end
    end

    // Every accepted result word is checked.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            table_model.check_result(m_tdata);
    end

    // Offers one input word and returns at the edge that accepts it.
    task automatic send_word(input cmd_t cmd, input logic [KEY_W-1:0] key,
                             input logic [VAL_W-1:0] value);
        if (tx_idle_on && $urandom_range(0, 5) == 0) begin
            @(negedge clk);
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 12) - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid = 1'b1;
        s_tuser  = cmd;
        s_tdata  = {value, key};
        do @(posedge clk); while (!s_tready);
        table_model.apply_word(cmd, key, value);
    endtask

    // Random key, with the signed extremes, zero and minus one now and then.
    function automatic logic [KEY_W-1:0] random_key();
        case ($urandom_range(0, 11))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Key for a search or an insert: mostly near what the table already holds.
    function automatic logic [KEY_W-1:0] pick_key();
        logic [KEY_W-1:0] base;
        if (table_model.count == 0 || $urandom_range(0, 3) == 0)
            return random_key();
        base = table_model.keys[$urandom_range(0, table_model.count - 1)];
        case ($urandom_range(0, 3))
            0:       return base + 1;
            1:       return base - 1;
            default: return base;
        endcase
    endfunction

    initial
    begin
        cmd_t cmd;
        table_model = new;

        // Reset held, then released on a falling edge.
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed words: signed extremes, a duplicate key, hits and misses.
        send_word(CMD_SEARCH, 32'h0000_0000, 32'hFFFF_FFFF);
        send_word(CMD_INSERT, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_word(CMD_INSERT, 32'h8000_0000, 32'h0000_0000);
        send_word(CMD_INSERT, 32'h0000_0000, 32'h8000_0000);
        send_word(CMD_INSERT, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        send_word(CMD_INSERT, 32'h0000_0000, 32'h1234_5678);
        send_word(CMD_INSERT, 32'h0000_0001, 32'hA5A5_A5A5);
        send_word(CMD_SEARCH, 32'h7FFF_FFFF, 32'h0000_0000);
        send_word(CMD_SEARCH, 32'h8000_0000, 32'h0000_0000);
        send_word(CMD_SEARCH, 32'h0000_0000, 32'h0000_0000);
        send_word(CMD_SEARCH, 32'hFFFF_FFFF, 32'h0000_0000);
        send_word(CMD_SEARCH, 32'h0000_0001, 32'h5A5A_5A5A);
        send_word(CMD_SEARCH, 32'h0000_0002, 32'h0000_0000);
        send_word(CMD_SEARCH, 32'h7FFF_FFFE, 32'h0000_0000);
        send_word(CMD_SEARCH, 32'h8000_0001, 32'h0000_0000);
        send_word(CMD_SEARCH, 32'hFFFF_FFFE, 32'hFFFF_FFFF);

        // Random words: the table fills slowly, then inserts are rejected.
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            tx_idle_on = (n < 1450) && ((n / 150) % 3 != 1) &&
                         !(n >= 700 && n < 790);
            rx_idle_on = (n < 1450) && ((n / 150) % 3 != 2);
            if (table_model.count < CAPACITY)
                cmd = ($urandom_range(0, 7) == 0) ? CMD_INSERT : CMD_SEARCH;
            else
                cmd = ($urandom_range(0, 3) == 0) ? CMD_INSERT : CMD_SEARCH;
            send_word(cmd, pick_key(), $urandom);
            // Long hold-off on the result side while words keep coming.
            if (n == 700)
                stall_request = 1'b1;
        end
        @(negedge clk);
        s_tvalid = 1'b0;

        // Drain the outstanding results.
        while (table_model.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (table_model.mismatches == 0 && table_model.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
